// ===== rtl/core/linear_interp_resampler_core_assert.svh =====
// Assertion macros shared by the resampler core modules.
// Depends on nothing; included by the controller and the datapath.
`ifndef LINEAR_INTERP_RESAMPLER_CORE_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define LIR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define LIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/core/lir_pkg.sv =====
// Package for the linear interpolation resampler core: widths, constants,
// register indexes and the controller/datapath command and status types.
`default_nettype none

package lir_pkg;

    // Fixed-point format of the phase accumulator.
    localparam int FRAC_BITS    = 15;
    localparam int MAX_UPSAMPLE = 8;
    localparam int ACC_W        = 20;
    localparam int SAMPLE_W     = 16;
    localparam int CC_W         = 2;
    localparam int CNT_W        = $clog2(MAX_UPSAMPLE);
    localparam int CFG_IDX_W    = 1;

    localparam int ONE_FRAME = 1 << FRAC_BITS;
    localparam int HALF_LSB  = 1 << (FRAC_BITS - 1);
    localparam int STEP_MIN  = (ONE_FRAME + MAX_UPSAMPLE - 1) / MAX_UPSAMPLE;
    localparam int STEP_MAX  = 524288;

    // Reset values of the configuration registers.
    localparam int CC_RESET   = 2;
    localparam int STEP_RESET = 32768;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 1'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // an item is taken this cycle
        logic skip;     // item causes no output; take one frame off the phase
        logic issue;    // start one interpolated output at the current phase
        logic last;     // the issued output ends the run for this item
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic phase_below;  // phase is below one frame
        logic next_below;   // phase plus step is below one frame
        logic pipe_free;    // the multiply stage can take a new output
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/core/lir_if.sv =====
// Channel interfaces of the resampler core: input frames, output frames and
// configuration writes. Depends on lir_pkg.
`default_nettype none

interface lir_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [lir_pkg::SAMPLE_W-1:0]   in_left;
    logic signed [lir_pkg::SAMPLE_W-1:0]   in_right;

    modport source (output valid, output in_left, output in_right, input ready);
    modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

interface lir_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [lir_pkg::SAMPLE_W-1:0]   out_left;
    logic signed [lir_pkg::SAMPLE_W-1:0]   out_right;
    logic                                  last_of_run;

    modport source (output valid, output out_left, output out_right,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_left, input out_right,
                    input last_of_run, output ready);
endinterface

interface lir_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [lir_pkg::CFG_IDX_W-1:0]         index;
    logic [lir_pkg::ACC_W-1:0]             data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/linear_interp_resampler_core.sv =====
// Top level of the linear interpolation resampler: joins the controller and
// the datapath. Depends on lir_pkg, lir_if, lir_ctrl and lir_dp.
//
//  Port    | Dir | Carries                                  | Accepted when
//  i_in    | in  | in_left, in_right (one frame)            | valid && ready
//  o_out   | out | out_left, out_right, last_of_run         | valid && ready
//  i_cfg   | in  | index (0 channel count, 1 phase step)    | valid && ready
//
// An item is taken only while no run is being issued; a frame that causes
// k outputs (k <= 8) issues one output per cycle while the output does not
// stall, and the next item is taken the cycle after. A frame that causes no
// output keeps the idle state; outputs pass the multiply and output registers.
// Reset is synchronous and active low; there is no clearing pass.
// A stalled output holds the multiply stage and then the issue sequence.
`default_nettype none

module linear_interp_resampler_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lir_in_if.sink      i_in,
    lir_out_if.source   o_out,
    lir_cfg_if.sink     i_cfg
);

    lir_pkg::t_cmd      cmd;
    lir_pkg::t_status   status;

    lir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lir_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_out      (o_out),
        .i_cfg      (i_cfg),
        .i_cmd      (cmd),
        .o_status   (status)
    );

endmodule

`default_nettype wire

// ===== rtl/core/lir_ctrl.sv =====
// Controller of the resampler core: takes items and sequences the outputs
// of each run. Depends on lir_pkg and the assertion macro header.
`default_nettype none
`include "linear_interp_resampler_core_assert.svh"

module lir_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire lir_pkg::t_status i_status,
    output lir_pkg::t_cmd         o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state                      r_state, n_state;
    logic [lir_pkg::CNT_W-1:0]   r_count, n_count;
    logic                        r_primed, n_primed;
    logic                        accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Command decode and next state.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_primed = r_primed;
        o_cmd    = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.accept = 1'b1;
                    n_primed     = 1'b1;
                    // The first frame only loads; a phase at or past one frame skips.
                    if (r_primed) begin
                        if (i_status.phase_below) begin
                            n_state = ST_RUN;
                            n_count = '0;
                        end else begin
                            o_cmd.skip = 1'b1;
                        end
                    end
                end
            end
            ST_RUN: begin
                if (i_status.pipe_free) begin
                    o_cmd.issue = 1'b1;
                    o_cmd.last  = !i_status.next_below
                               || (r_count == lir_pkg::CNT_W'(lir_pkg::MAX_UPSAMPLE - 1));
                    if (o_cmd.last) begin
                        n_state = ST_IDLE;
                        n_count = '0;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_primed <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_primed <= n_primed;
        end
    end

    `LIR_ASSERT_NEXT(a_last_returns_idle, i_clk, i_rst_n, o_cmd.issue && o_cmd.last, r_state == ST_IDLE && r_count == '0)
    `LIR_ASSERT_NEXT(a_accept_primes, i_clk, i_rst_n, o_cmd.accept, r_primed)
    `LIR_ASSERT_IMPLY(a_run_needs_prime, i_clk, i_rst_n, r_state == ST_RUN, r_primed)

endmodule

`default_nettype wire

// ===== rtl/core/lir_dp.sv =====
// Datapath of the resampler core: configuration registers, previous frame,
// phase accumulator, multiply stage and output register. Depends on lir_pkg,
// lir_if and the assertion macro header.
`default_nettype none
`include "linear_interp_resampler_core_assert.svh"

module lir_dp (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    lir_in_if.sink                i_in,
    lir_out_if.source             o_out,
    lir_cfg_if.sink               i_cfg,
    input  wire lir_pkg::t_cmd    i_cmd,
    output lir_pkg::t_status      o_status
);

    localparam int SW     = lir_pkg::SAMPLE_W;
    localparam int AW     = lir_pkg::ACC_W;
    localparam int FB     = lir_pkg::FRAC_BITS;
    localparam int DIFF_W = SW + 1;
    localparam int PROD_W = DIFF_W + FB + 1;
    localparam int SHR_W  = PROD_W - FB;
    localparam int Q_W    = SHR_W + 1;

    // Clamp a quotient to the signed sample range.
    function automatic logic [SW-1:0] sat(input logic [Q_W-1:0] v);
        logic [Q_W-SW:0] top;
        top = v[Q_W-1:SW-1];
        if ((&top) || !(|top)) begin
            sat = v[SW-1:0];
        end else if (v[Q_W-1]) begin
            sat = {1'b1, {(SW-1){1'b0}}};
        end else begin
            sat = {1'b0, {(SW-1){1'b1}}};
        end
    endfunction

    logic [lir_pkg::CC_W-1:0]  r_channel_count;
    logic [AW-1:0]             r_step;
    logic [AW-1:0]             n_step;
    logic                      stereo;

    logic [SW-1:0]             r_prev_l, r_prev_r;
    logic [SW-1:0]             r_base_l, r_base_r;
    logic signed [DIFF_W-1:0]  r_diff_l, r_diff_r;
    logic [AW-1:0]             r_phase;
    logic [AW:0]               phase_sum;

    logic                      r_m_valid, r_m_last, r_m_stereo;
    logic signed [PROD_W-1:0]  r_m_prod_l, r_m_prod_r;
    logic [SW-1:0]             r_m_base_l, r_m_base_r;
    logic signed [FB:0]        weight;

    logic                      r_o_valid, r_o_last;
    logic [SW-1:0]             r_o_left, r_o_right;
    logic                      advance_o, advance_m;

    logic signed [PROD_W-1:0]  rnd_l, rnd_r;
    logic [Q_W-1:0]            q_l, q_r;

    // Configuration writes; the step is stored already clamped.
    assign i_cfg.ready = 1'b1;
    assign stereo      = r_channel_count[1];

    always_comb begin
        if (i_cfg.data < AW'(lir_pkg::STEP_MIN)) begin
            n_step = AW'(lir_pkg::STEP_MIN);
        end else if (i_cfg.data > AW'(lir_pkg::STEP_MAX)) begin
            n_step = AW'(lir_pkg::STEP_MAX);
        end else begin
            n_step = i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= lir_pkg::CC_W'(lir_pkg::CC_RESET);
            r_step          <= AW'(lir_pkg::STEP_RESET);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                lir_pkg::CFG_CHANNEL_COUNT: r_channel_count <= i_cfg.data[lir_pkg::CC_W-1:0];
                lir_pkg::CFG_PHASE_STEP:    r_step          <= n_step;
                default: ;
            endcase
        end
    end

    // Status for the controller.
    assign phase_sum            = {1'b0, r_phase} + {1'b0, r_step};
    assign o_status.phase_below = r_phase < AW'(lir_pkg::ONE_FRAME);
    assign o_status.next_below  = phase_sum < (AW+1)'(lir_pkg::ONE_FRAME);
    assign advance_o            = !r_o_valid || o_out.ready;
    assign advance_m            = !r_m_valid || advance_o;
    assign o_status.pipe_free   = advance_m;

    // Previous frame and phase accumulator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_l <= '0;
            r_prev_r <= '0;
            r_phase  <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_prev_l <= i_in.in_left;
                r_prev_r <= i_in.in_right;
            end
            if (i_cmd.skip) begin
                r_phase <= r_phase - AW'(lir_pkg::ONE_FRAME);
            end else if (i_cmd.issue) begin
                if (!i_cmd.last) begin
                    r_phase <= phase_sum[AW-1:0];
                end else if (o_status.next_below) begin
                    r_phase <= '0;
                end else begin
                    r_phase <= AW'(phase_sum - (AW+1)'(lir_pkg::ONE_FRAME));
                end
            end
        end
    end

    // Base and difference of the frame pair, taken with the item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_base_l <= r_prev_l;
            r_base_r <= r_prev_r;
            r_diff_l <= signed'({i_in.in_left[SW-1], i_in.in_left})
                      - signed'({r_prev_l[SW-1], r_prev_l});
            r_diff_r <= signed'({i_in.in_right[SW-1], i_in.in_right})
                      - signed'({r_prev_r[SW-1], r_prev_r});
        end
    end

    // Multiply stage: difference times the fractional phase.
    assign weight = signed'({1'b0, r_phase[FB-1:0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.issue) begin
            r_m_valid <= 1'b1;
        end else if (advance_o) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_m_prod_l <= PROD_W'(r_diff_l * weight);
            r_m_prod_r <= PROD_W'(r_diff_r * weight);
            r_m_base_l <= r_base_l;
            r_m_base_r <= r_base_r;
            r_m_last   <= i_cmd.last;
            r_m_stereo <= stereo;
        end
    end

    // Output stage: round, add the base, saturate; the right output is zero in mono.
    assign rnd_l = r_m_prod_l + PROD_W'(lir_pkg::HALF_LSB);
    assign rnd_r = r_m_prod_r + PROD_W'(lir_pkg::HALF_LSB);
    assign q_l   = {{(Q_W-SW){r_m_base_l[SW-1]}}, r_m_base_l}
                 + {rnd_l[PROD_W-1], rnd_l[PROD_W-1:FB]};
    assign q_r   = {{(Q_W-SW){r_m_base_r[SW-1]}}, r_m_base_r}
                 + {rnd_r[PROD_W-1], rnd_r[PROD_W-1:FB]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (advance_o) begin
            r_o_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance_o && r_m_valid) begin
            r_o_left  <= sat(q_l);
            r_o_right <= r_m_stereo ? sat(q_r) : '0;
            r_o_last  <= r_m_last;
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.out_left    = r_o_left;
    assign o_out.out_right   = r_o_right;
    assign o_out.last_of_run = r_o_last;

    `LIR_ASSERT_IMPLY(a_issue_phase_in_frame, i_clk, i_rst_n, i_cmd.issue, r_phase < AW'(lir_pkg::ONE_FRAME))
    `LIR_ASSERT_NEXT(a_mul_held_on_stall, i_clk, i_rst_n, r_m_valid && !advance_o, r_m_valid)
    `LIR_ASSERT_IMPLY(a_issue_needs_room, i_clk, i_rst_n, i_cmd.issue, advance_m)

endmodule

`default_nettype wire

// ===== tb/tb_linear_interp_resampler_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for linear_interp_resampler_core: drives frames and register
// writes, predicts every interpolated output frame and checks each one as it leaves.
// Depends on lir_pkg, the channel interfaces in lir_if and the core RTL.

module tb_linear_interp_resampler_core;
    import lir_pkg::*;

    localparam int     STALL_LIMIT     = 2000;
    localparam int     SETTLE_CYCLES   = 8;
    localparam int     RESET_CYCLES    = 7;
    localparam int     RANDOM_PHASES   = 9;
    localparam int     ITEMS_PER_PHASE = 37;
    localparam longint SAMPLE_MAX      = 32767;
    localparam longint SAMPLE_MIN      = -32768;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idling;

    typedef struct {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       last_of_run;
    } t_out_frame;

    logic clk = 1'b0;
    logic rst_n;

    lir_in_if  frame_in ();
    lir_out_if frame_out ();
    lir_cfg_if cfg_bus ();

    linear_interp_resampler_core uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (frame_in),
        .o_out   (frame_out),
        .i_cfg   (cfg_bus)
    );

    // Predicted register and stream state of the resampler.
    logic [CC_W-1:0]            pred_channels;
    logic [ACC_W-1:0]           pred_step;
    logic signed [SAMPLE_W-1:0] pred_prev_left;
    logic signed [SAMPLE_W-1:0] pred_prev_right;
    logic [ACC_W-1:0]           pred_phase;
    logic                       pred_primed;

    t_out_frame pending_frames[$];
    t_out_frame head_frame;
    int         error_count        = 0;
    int         idle_cycles        = 0;
    int         sender_idle_pct    = 0;
    int         receiver_stall_pct = 0;

    // 50 MHz clock.
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_error(input string msg);
        $display("%0t ns: %s", $time, msg);
        error_count++;
    endtask

    // One channel of prev*(1-pos) + cur*pos, rounded half up and saturated.
    function automatic logic signed [SAMPLE_W-1:0] mix_channel(
        input logic signed [SAMPLE_W-1:0] prev,
        input logic signed [SAMPLE_W-1:0] cur,
        input int                         pos
    );
        longint acc;
        acc = longint'(prev) * longint'(ONE_FRAME - pos) + longint'(cur) * longint'(pos)
            + longint'(HALF_LSB);
        acc = acc >>> FRAC_BITS;
        if (acc > SAMPLE_MAX) begin
            acc = SAMPLE_MAX;
        end else if (acc < SAMPLE_MIN) begin
            acc = SAMPLE_MIN;
        end
        return acc[SAMPLE_W-1:0];
    endfunction

    // Works out the output frames that one accepted input frame causes.
    function automatic void predict_frame(
        input logic signed [SAMPLE_W-1:0] cur_left,
        input logic signed [SAMPLE_W-1:0] cur_right
    );
        int         pos;
        int         step;
        int         count;
        bit         stereo;
        t_out_frame frame;
        pos    = int'(pred_phase);
        step   = int'(pred_step);
        count  = 0;
        stereo = (pred_channels >= 2);
        if (step < STEP_MIN) begin
            step = STEP_MIN;
        end
        if (step > STEP_MAX) begin
            step = STEP_MAX;
        end
        if (pred_primed) begin
            while (pos < ONE_FRAME && count < MAX_UPSAMPLE) begin
                frame.left  = mix_channel(pred_prev_left, cur_left, pos);
                frame.right = stereo ? mix_channel(pred_prev_right, cur_right, pos) : '0;
                count++;
                frame.last_of_run = !(pos + step < ONE_FRAME && count < MAX_UPSAMPLE);
                pending_frames.push_back(frame);
                pos += step;
            end
            pos        = (pos >= ONE_FRAME) ? pos - ONE_FRAME : 0;
            pred_phase = pos[ACC_W-1:0];
        end
        pred_prev_left  = cur_left;
        pred_prev_right = cur_right;
        pred_primed     = 1'b1;
    endfunction

    // Random sample: mostly full range, sometimes an extreme or a small step.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample(
        input logic signed [SAMPLE_W-1:0] near
    );
        case ($urandom_range(9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2, 3: return near + SAMPLE_W'($urandom_range(511)) - SAMPLE_W'(256);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic set_idling(input t_idling mode);
        case (mode)
            IDLE_NONE: begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            IDLE_SENDER: begin
                sender_idle_pct    = 73;
                receiver_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 73;
            end
            default: begin
                sender_idle_pct    = 24;
                receiver_stall_pct = 24;
            end
        endcase
    endtask

    // Offers one frame, with random idle cycles first, and predicts it once taken.
    // Valid stays high afterwards so that back-to-back frames need no gap.
    task automatic send_frame(
        input logic signed [SAMPLE_W-1:0] left,
        input logic signed [SAMPLE_W-1:0] right
    );
        while ($urandom_range(99) < sender_idle_pct) begin
            frame_in.valid <= 1'b0;
            @(posedge clk);
        end
        frame_in.valid    <= 1'b1;
        frame_in.in_left  <= left;
        frame_in.in_right <= right;
        @(posedge clk);
        while (!frame_in.ready) begin
            @(posedge clk);
        end
        predict_frame(left, right);
    endtask

    // Stops the input and waits until every predicted frame has arrived, then lets
    // the pipeline settle in case the last frame caused no output.
    task automatic wait_drained();
        frame_in.valid <= 1'b0;
        while (pending_frames.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [ACC_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready) begin
            @(posedge clk);
        end
        case (idx)
            CFG_CHANNEL_COUNT: pred_channels = value[CC_W-1:0];
            default:           pred_step     = value;
        endcase
    endtask

    // Writes both registers while the block is idle. The upper data bits of the
    // channel count write are random, as the block keeps only the low bits.
    task automatic configure(input logic [CC_W-1:0] channels, input logic [ACC_W-1:0] step);
        logic [ACC_W-1:0] cc_word;
        cc_word             = ACC_W'($urandom);
        cc_word[CC_W-1:0]   = channels;
        wait_drained();
        write_register(CFG_CHANNEL_COUNT, cc_word);
        write_register(CFG_PHASE_STEP, step);
        cfg_bus.valid <= 1'b0;
    endtask

    // First frame after reset only loads; then one output per frame at full scale.
    task automatic test_first_frame_and_extremes();
        set_idling(IDLE_NONE);
        send_frame(16'sh7FFF, 16'sh8000);
        send_frame(16'sh8000, 16'sh7FFF);
        send_frame(16'sh0000, 16'sh0000);
        send_frame(-16'sd1, 16'sd1);
        send_frame(16'sh7FFF, 16'sh7FFF);
        send_frame(16'sh8000, 16'sh8000);
    endtask

    // Mono, channel count zero acting as mono, and three acting as stereo. The right
    // samples latched while mono are used as soon as stereo returns.
    task automatic test_channel_modes();
        set_idling(IDLE_BOTH);
        configure(2'd1, 20'd16384);
        send_frame(16'sd1000, -16'sd1000);
        send_frame(-16'sd2000, 16'sh7FFF);
        send_frame(16'sh7FFF, 16'sh8000);
        configure(2'd0, 20'd16384);
        send_frame(-16'sd3, 16'sd12345);
        send_frame(16'sd9, -16'sd4321);
        configure(2'd3, 20'd16384);
        send_frame(16'sd5, 16'sd7);
        send_frame(16'sh8000, 16'sh7FFF);
    endtask

    // Steps below the minimum and above the maximum are clamped; the large step
    // skips input frames.
    task automatic test_step_limits();
        set_idling(IDLE_RECEIVER);
        configure(2'd2, 20'd0);
        send_frame(16'sh7FFF, 16'sh8000);
        send_frame(16'sh8000, 16'sh7FFF);
        send_frame(16'sd100, -16'sd100);
        configure(2'd2, 20'hFFFFF);
        send_frame(16'sd1, 16'sd2);
        send_frame(16'sd3, 16'sd4);
        send_frame(16'sd5, 16'sd6);
        configure(2'd2, ACC_W'(STEP_MIN));
        send_frame(-16'sd7, 16'sd7);
        send_frame(16'sh7FFF, 16'sh7FFF);
        configure(2'd2, ACC_W'(STEP_MAX));
        send_frame(16'sd11, 16'sd12);
        send_frame(16'sd13, 16'sd14);
    endtask

    // The sender holds off mid-stream until every output has been taken.
    task automatic test_pause_until_drained();
        set_idling(IDLE_BOTH);
        configure(2'd2, 20'd12000);
        repeat (8) send_frame(pick_sample(pred_prev_left), pick_sample(pred_prev_right));
        wait_drained();
        repeat (8) send_frame(pick_sample(pred_prev_left), pick_sample(pred_prev_right));
    endtask

    // Random frames over several register settings and idling patterns.
    task automatic test_random_traffic();
        logic [ACC_W-1:0] step;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            set_idling(t_idling'(phase % 4));
            case ($urandom_range(5))
                0, 1, 2: step = ACC_W'($urandom_range(2 * ONE_FRAME, STEP_MIN));
                3:       step = ACC_W'($urandom_range(STEP_MAX, 2 * ONE_FRAME));
                4:       step = ACC_W'($urandom_range(STEP_MIN, 0));
                default: step = ACC_W'($urandom);
            endcase
            configure(CC_W'($urandom_range(3)), step);
            repeat (ITEMS_PER_PHASE) begin
                send_frame(pick_sample(pred_prev_left), pick_sample(pred_prev_right));
            end
        end
    endtask

    // Receiver back-pressure.
    always @(posedge clk) begin
        frame_out.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Each output frame is compared with the oldest prediction.
    always @(posedge clk) begin
        if (rst_n === 1'b1 && frame_out.valid === 1'b1 && frame_out.ready === 1'b1) begin
            if (pending_frames.size() == 0) begin
                report_error($sformatf("unexpected output frame left=%0d right=%0d last=%0b",
                             frame_out.out_left, frame_out.out_right,
                             frame_out.last_of_run));
            end else begin
                head_frame = pending_frames.pop_front();
                if (frame_out.out_left !== head_frame.left) begin
                    report_error($sformatf("out_left: expected %0d, got %0d",
                                 head_frame.left, frame_out.out_left));
                end
                if (frame_out.out_right !== head_frame.right) begin
                    report_error($sformatf("out_right: expected %0d, got %0d",
                                 head_frame.right, frame_out.out_right));
                end
                if (frame_out.last_of_run !== head_frame.last_of_run) begin
                    report_error($sformatf("last_of_run: expected %0b, got %0b",
                                 head_frame.last_of_run, frame_out.last_of_run));
                end
            end
        end
    end

    // Watchdog: ends the run when no channel has moved an item for too long.
    always @(posedge clk) begin
        if ((frame_in.valid && frame_in.ready) || (frame_out.valid && frame_out.ready)
                || (cfg_bus.valid && cfg_bus.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles", idle_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        rst_n             <= 1'b0;
        frame_in.valid    <= 1'b0;
        frame_in.in_left  <= '0;
        frame_in.in_right <= '0;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.index     <= CFG_CHANNEL_COUNT;
        cfg_bus.data      <= '0;
        pred_channels     = CC_W'(CC_RESET);
        pred_step         = ACC_W'(STEP_RESET);
        pred_prev_left    = '0;
        pred_prev_right   = '0;
        pred_phase        = '0;
        pred_primed       = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_frame_and_extremes();
        test_channel_modes();
        test_step_limits();
        test_pause_until_drained();
        test_random_traffic();
        wait_drained();

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== linear_interp_resampler_core.f =====
+incdir+rtl/core
rtl/core/lir_pkg.sv
rtl/core/lir_if.sv
rtl/core/lir_ctrl.sv
rtl/core/lir_dp.sv
rtl/core/linear_interp_resampler_core.sv
tb/tb_linear_interp_resampler_core.sv
